// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/rsakd_pkg.sv =====
// Package with shared constants and types of the RSA key derivation block.
package rsakd_pkg;
  localparam int unsigned PrimeBitsDef = 32;
  localparam int unsigned WordBits     = 64;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusSmall     = 3'd1;
  localparam logic [2:0] StatusNotCoprim = 3'd2;
  localparam logic [2:0] StatusPComp     = 3'd3;
  localparam logic [2:0] StatusQComp     = 3'd4;

  // Request and answer of the shared divider.
  typedef struct packed {
    logic              start;
    logic [WordBits-1:0] dividend;
    logic [WordBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WordBits-1:0] quot;
    logic [WordBits-1:0] rem;
  } div_rsp_t;
endpackage

// ===== rtl/core/rsakd_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module rsakd_divider
  import rsakd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntBits = $clog2(WordBits);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] quo_q, quo_d;
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits-1:0] dsr_q, dsr_d;
  logic [WordBits:0]   trial;
  logic [WordBits:0]   shifted;

  // One restoring step: shift in next dividend bit, subtract when it fits.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, quo_q[WordBits-1]};
    trial   = shifted - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[WordBits]) begin
        rem_d = trial[WordBits-1:0];
        quo_d = {quo_q[WordBits-2:0], 1'b1};
      end else begin
        rem_d = shifted[WordBits-1:0];
        quo_d = {quo_q[WordBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(WordBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule

// ===== rtl/core/rsakd_seq.sv =====
// Sequencer that runs checks, gcd and inverse steps on the shared divider.
module rsakd_seq
  import rsakd_pkg::*;
#(
  parameter int unsigned PRIME_BITS = PrimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PRIME_BITS-1:0] p_i,
  input  logic [PRIME_BITS-1:0] q_i,
  input  logic [WordBits-1:0]   e_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [2:0]            status_o,
  output logic                  flag_o,
  output logic [WordBits-1:0]   n_o,
  output logic [WordBits-1:0]   phi_o,
  output logic [WordBits-1:0]   d_o,
  output logic [WordBits-1:0]   dmin_o,
  output div_req_t              div_req_o,
  input  div_rsp_t              div_rsp_i
);
  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SMulN    = 5'd1;
  localparam logic [4:0] SMulPhi  = 5'd2;
  localparam logic [4:0] SGcdE    = 5'd3;
  localparam logic [4:0] SGcdEW   = 5'd4;
  localparam logic [4:0] SPrimP   = 5'd5;
  localparam logic [4:0] SPrimW   = 5'd6;
  localparam logic [4:0] SGcdPq   = 5'd7;
  localparam logic [4:0] SGcdPqW  = 5'd8;
  localparam logic [4:0] SLam     = 5'd9;
  localparam logic [4:0] SLamW    = 5'd10;
  localparam logic [4:0] SInv     = 5'd11;
  localparam logic [4:0] SInvW0   = 5'd12;
  localparam logic [4:0] SInvLp   = 5'd13;
  localparam logic [4:0] SInvLpW  = 5'd14;
  localparam logic [4:0] SInvMul  = 5'd15;
  localparam logic [4:0] SInvFin  = 5'd16;
  localparam logic [4:0] SInvFW   = 5'd17;
  localparam logic [4:0] SDone    = 5'd18;
  localparam logic [4:0] SOut     = 5'd19;
  localparam logic [4:0] SPrimSq  = 5'd20;
  localparam logic [4:0] SInvMulH = 5'd21;
  localparam logic [4:0] SInvMulL = 5'd22;

  logic [4:0]          st_q, st_d;
  logic [WordBits-1:0] p_q, p_d, q_q, q_d, e_q, e_d;
  logic [WordBits-1:0] a_q, a_d, b_q, b_d;
  logic [WordBits-1:0] tp_q, tp_d, tc_q, tc_d;
  logic [WordBits-1:0] qq_q, qq_d, m_q, m_d;
  logic [WordBits-1:0] dv_q, dv_d, cand_q, cand_d;
  logic [WordBits-1:0] n_q, n_d, phi_q, phi_d, d_q, d_d, dm_q, dm_d, lam_q, lam_d;
  logic [WordBits-1:0] acc_q, acc_d;
  logic [2:0]          status_q, status_d;
  logic                flag_q, flag_d;
  logic                steps_q, steps_d;
  logic                which_q, which_d;
  logic                second_q, second_d;
  logic [31:0]         mul_a, mul_b;
  logic [WordBits-1:0] mul_y;
  div_req_t            req;

  // One 32x32 multiplier is shared by all products.
  always_comb begin
    mul_y = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    st_d = st_q; p_d = p_q; q_d = q_q; e_d = e_q;
    a_d = a_q; b_d = b_q; tp_d = tp_q; tc_d = tc_q; qq_d = qq_q; m_d = m_q;
    dv_d = dv_q; cand_d = cand_q; n_d = n_q; phi_d = phi_q; d_d = d_q;
    dm_d = dm_q; lam_d = lam_q; status_d = status_q; flag_d = flag_q;
    steps_d = steps_q; which_d = which_q; second_d = second_q;
    acc_d = acc_q;
    req = '0;
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      SIdle: begin
        if (in_valid_i) begin
          p_d = WordBits'(p_i);
          q_d = WordBits'(q_i);
          e_d = e_i;
          st_d = SMulN;
        end
      end
      SMulN: begin
        status_d = StatusOk; flag_d = 1'b0; n_d = '0; phi_d = '0; d_d = '0; dm_d = '0;
        if (p_q < 64'd2 || q_q < 64'd2) begin
          status_d = StatusSmall;
          st_d = SOut;
        end else begin
          flag_d = (e_q == 64'd1);
          mul_a = p_q[31:0]; mul_b = q_q[31:0];
          n_d = mul_y;
          st_d = SMulPhi;
        end
      end
      SMulPhi: begin
        mul_a = p_q[31:0] - 32'd1; mul_b = q_q[31:0] - 32'd1;
        phi_d = mul_y;
        a_d = e_q; b_d = mul_y;
        st_d = SGcdE;
      end
      // gcd(e, phi) by repeated remainders.
      SGcdE: begin
        if (b_q == '0) begin
          if (a_q > 64'd1) begin
            status_d = StatusNotCoprim;
            st_d = SOut;
          end else begin
            which_d = 1'b0;
            cand_d = p_q;
            st_d = SPrimP;
          end
        end else begin
          req.start = 1'b1; req.dividend = a_q; req.divisor = b_q;
          st_d = SGcdEW;
        end
      end
      SGcdEW: begin
        if (div_rsp_i.done) begin
          a_d = b_q; b_d = div_rsp_i.rem;
          st_d = SGcdE;
        end
      end
      // Primality of the candidate by trial division over odd divisors.
      SPrimP: begin
        dv_d = 64'd3;
        if (cand_q == 64'd2) begin
          st_d = which_q ? SGcdPq : SPrimP;
          if (!which_q) begin
            which_d = 1'b1; cand_d = q_q;
          end else begin
            a_d = p_q - 64'd1; b_d = q_q - 64'd1;
          end
        end else if (!cand_q[0]) begin
          status_d = which_q ? StatusQComp : StatusPComp;
          st_d = SOut;
        end else begin
          st_d = SPrimSq;
        end
      end
      SPrimSq: begin
        mul_a = dv_q[31:0]; mul_b = dv_q[31:0];
        if (mul_y > cand_q) begin
          if (!which_q) begin
            which_d = 1'b1; cand_d = q_q; st_d = SPrimP;
          end else begin
            a_d = p_q - 64'd1; b_d = q_q - 64'd1; st_d = SGcdPq;
          end
        end else begin
          req.start = 1'b1; req.dividend = cand_q; req.divisor = dv_q;
          st_d = SPrimW;
        end
      end
      SPrimW: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.rem == '0) begin
            status_d = which_q ? StatusQComp : StatusPComp;
            st_d = SOut;
          end else begin
            dv_d = dv_q + 64'd2;
            st_d = SPrimSq;
          end
        end
      end
      SGcdPq: begin
        if (b_q == '0) begin
          req.start = 1'b1; req.dividend = phi_q; req.divisor = a_q;
          st_d = SLamW;
        end else begin
          req.start = 1'b1; req.dividend = a_q; req.divisor = b_q;
          st_d = SGcdPqW;
        end
      end
      SGcdPqW: begin
        if (div_rsp_i.done) begin
          a_d = b_q; b_d = div_rsp_i.rem; st_d = SGcdPq;
        end
      end
      SLam: st_d = SLamW;
      SLamW: begin
        if (div_rsp_i.done) begin
          lam_d = div_rsp_i.quot;
          m_d = phi_q; second_d = 1'b0;
          st_d = SInv;
        end
      end
      // Extended Euclid: r_prev in a, r_cur in b.
      SInv: begin
        if (m_q <= 64'd1) begin
          tc_d = '0;
          st_d = SDone;
        end else begin
          req.start = 1'b1; req.dividend = e_q; req.divisor = m_q;
          st_d = SInvW0;
        end
      end
      SInvW0: begin
        if (div_rsp_i.done) begin
          a_d = m_q; b_d = div_rsp_i.rem;
          tp_d = '0; tc_d = 64'd1; steps_d = 1'b0;
          st_d = SInvLp;
        end
      end
      SInvLp: begin
        if (b_q == '0) begin
          req.start = 1'b1; req.dividend = tp_q; req.divisor = m_q;
          st_d = SInvFW;
        end else begin
          req.start = 1'b1; req.dividend = a_q; req.divisor = b_q;
          st_d = SInvLpW;
        end
      end
      SInvLpW: begin
        if (div_rsp_i.done) begin
          qq_d = div_rsp_i.quot;
          a_d = b_q; b_d = div_rsp_i.rem;
          st_d = SInvMul;
        end
      end
      // The product of quotient and coefficient stays below m, so its low
      // 64 bits are built from three 32x32 partial products in SInvMul, SInvMulH and SInvMulL.
      SInvMul: begin
        mul_a = qq_q[31:0]; mul_b = tc_q[31:0];
        acc_d = mul_y;
        st_d = SInvMulH;
      end
      SInvMulH: begin
        mul_a = qq_q[31:0]; mul_b = tc_q[63:32];
        acc_d = acc_q + {mul_y[31:0], 32'd0};
        st_d = SInvMulL;
      end
      SInvMulL: begin
        mul_a = qq_q[63:32]; mul_b = tc_q[31:0];
        tp_d = tc_q;
        tc_d = tp_q + acc_q + {mul_y[31:0], 32'd0};
        steps_d = ~steps_q;
        st_d = SInvLp;
      end
      SInvFW: begin
        if (div_rsp_i.done) begin
          tc_d = (!steps_q && div_rsp_i.rem != '0) ? m_q - div_rsp_i.rem : div_rsp_i.rem;
          st_d = SDone;
        end
      end
      SInvFin: st_d = SDone;
      SDone: begin
        if (!second_q) begin
          d_d = tc_q; m_d = lam_q; second_d = 1'b1; st_d = SInv;
        end else begin
          dm_d = tc_q; st_d = SOut;
        end
      end
      SOut: begin
        if (status_q != StatusOk) begin
          n_d = '0; phi_d = '0; d_d = '0; dm_d = '0;
        end
        if (res_ready_i && res_valid_o) st_d = SIdle;
        else st_d = SOut;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; q_q <= q_d; e_q <= e_d; a_q <= a_d; b_q <= b_d;
    tp_q <= tp_d; tc_q <= tc_d; qq_q <= qq_d; m_q <= m_d; dv_q <= dv_d;
    cand_q <= cand_d; n_q <= n_d; phi_q <= phi_d; d_q <= d_d; dm_q <= dm_d;
    lam_q <= lam_d; status_q <= status_d; flag_q <= flag_d; steps_q <= steps_d;
    which_q <= which_d; second_q <= second_d; acc_q <= acc_d;
  end

  assign div_req_o   = req;
  assign in_ready_o  = (st_q == SIdle);
  assign res_valid_o = (st_q == SOut);
  assign status_o    = status_q;
  assign flag_o      = flag_q;
  assign n_o   = (status_q == StatusOk) ? n_q : '0;
  assign phi_o = (status_q == StatusOk) ? phi_q : '0;
  assign d_o   = (status_q == StatusOk) ? d_q : '0;
  assign dmin_o = (status_q == StatusOk) ? dm_q : '0;
endmodule

// ===== rtl/core/rsa_key_derivation.sv =====
// Top level of the RSA key derivation block.
// Usage: present p, q and e on the input channel with in_valid_i; the item is
// taken when in_ready_o is also high. The block then works on it alone and
// holds in_ready_o low until its single result transaction is taken.
// The result channel shows status, the exponent-one flag, the modulus, the
// totient and both private exponents; on error the last four read zero.
// Latency is data dependent: every remainder is computed on the shared 64-bit
// serial divider. Trial division runs up to sqrt(p) / 2 such divisions per
// factor, and each Euclid loop about 1.5 * 64 steps at most.
// When the receiver stalls, the result holds steady on the outputs and no
// new item is accepted. Reset returns the sequencer to idle at once; there
// is no clearing pass.
module rsa_key_derivation
  import rsakd_pkg::*;
#(
  parameter int unsigned PRIME_BITS = PrimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           prime_p_i,
  input  logic [31:0]           prime_q_i,
  input  logic [63:0]           public_exp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic                  exp_is_one_o,
  output logic [63:0]           modulus_o,
  output logic [63:0]           totient_o,
  output logic [63:0]           private_exp_o,
  output logic [63:0]           private_exp_min_o
);
  div_req_t div_req;
  div_rsp_t div_rsp;

  rsakd_divider u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (div_req), .rsp_o (div_rsp)
  );

  rsakd_seq #(.PRIME_BITS (PRIME_BITS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .p_i         (prime_p_i[PRIME_BITS-1:0]),
    .q_i         (prime_q_i[PRIME_BITS-1:0]),
    .e_i         (public_exp_i),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .status_o    (status_o),
    .flag_o      (exp_is_one_o),
    .n_o         (modulus_o),
    .phi_o       (totient_o),
    .d_o         (private_exp_o),
    .dmin_o      (private_exp_min_o),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );
endmodule

// ===== rtl/core/rsakd_checker.sv =====
// Port-level checker for the RSA key derivation block and its bind.
`include "assert_macros.svh"
module rsakd_checker
  import rsakd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        exp_is_one_o,
  input logic [63:0] modulus_o
);
  // One item at a time: never ready while a result is shown.
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // Errors report a zero modulus.
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != StatusOk, modulus_o == 64'd0)
  // A small factor clears the exponent flag.
  `ASSERT_IMPL(a_flag, clk_i, rst_ni, out_valid_o && status_o == StatusSmall, !exp_is_one_o)
  // An accepted input drops ready next cycle.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A stalled result stays offered with the same modulus.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(modulus_o))
endmodule

bind rsa_key_derivation rsakd_checker u_chk (
  .clk_i (clk_i), .rst_ni (rst_ni), .in_valid_i (in_valid_i), .in_ready_o (in_ready_o),
  .out_valid_o (out_valid_o), .out_ready_i (out_ready_i), .status_o (status_o),
  .exp_is_one_o (exp_is_one_o), .modulus_o (modulus_o)
);

// ===== bench/tb_rsa_key_derivation.sv =====
// Testbench for the RSA key derivation block: directed, random and stall tests.
module tb_rsa_key_derivation
  import rsakd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  status;
    logic        flag;
    logic [63:0] n;
    logic [63:0] phi;
    logic [63:0] d;
    logic [63:0] dmin;
  } key_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] prime_p_i = '0;
  logic [31:0] prime_q_i = '0;
  logic [63:0] public_exp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        exp_is_one_o;
  logic [63:0] modulus_o;
  logic [63:0] totient_o;
  logic [63:0] private_exp_o;
  logic [63:0] private_exp_min_o;

  key_t expected_keys[$];
  int   mismatches = 0;
  bit   idle_en = 1'b1;
  int   hold_left = 0;
  int   stall_left = 0;

  rsa_key_derivation u_top (.*);

  always #2 clk_i = ~clk_i;

  // Greatest common divisor on 64-bit words.
  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Modular inverse by extended Euclid with alternating-sign magnitudes.
  function automatic logic [63:0] inv_mod64(logic [63:0] e, logic [63:0] m);
    logic [63:0] rp, rc, tp, tc, qq, rn, tn, t;
    int steps;
    if (m <= 1) return 0;
    rp = m;
    rc = e % m;
    tp = 0;
    tc = 1;
    steps = 0;
    while (rc != 0) begin
      qq = rp / rc;
      rn = rp - qq * rc;
      tn = tp + qq * tc;
      rp = rc;
      rc = rn;
      tp = tc;
      tc = tn;
      steps++;
    end
    t = tp % m;
    if (steps % 2 == 0 && t != 0) t = m - t;
    return t;
  endfunction

  // Trial division: two is prime, other even values are composite.
  function automatic bit not_prime(logic [63:0] v);
    logic [63:0] i;
    if (v == 2) return 1'b0;
    if (!v[0]) return 1'b1;
    for (i = 3; i * i <= v; i += 2)
      if (v % i == 0) return 1'b1;
    return 1'b0;
  endfunction

  // Expected key set for one request.
  function automatic key_t derive_key(logic [31:0] p32, logic [31:0] q32, logic [63:0] e);
    key_t k;
    logic [63:0] p, q, lambda;
    p = 64'(p32);
    q = 64'(q32);
    k = '{StatusOk, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0};
    if (p < 2 || q < 2) begin
      k.status = StatusSmall;
    end else begin
      k.flag = (e == 1);
      k.phi = (p - 1) * (q - 1);
      if (gcd64(e, k.phi) > 1) k.status = StatusNotCoprim;
      else if (not_prime(p)) k.status = StatusPComp;
      else if (not_prime(q)) k.status = StatusQComp;
    end
    if (k.status == StatusOk) begin
      lambda = k.phi / gcd64(p - 1, q - 1);
      k.n = p * q;
      k.d = inv_mod64(e, k.phi);
      k.dmin = inv_mod64(e, lambda);
    end else begin
      k.phi = 0;
    end
    return k;
  endfunction

  // Smallest prime at or above a random point of the range.
  function automatic logic [31:0] random_prime(int unsigned hi);
    logic [31:0] v;
    v = $urandom_range(2, hi);
    if (v != 2 && !v[0]) v++;
    while (not_prime(64'(v))) v += 2;
    return v;
  endfunction

  // Drive one request and record its expected key once it is accepted.
  task automatic send_request(logic [31:0] p, logic [31:0] q, logic [63:0] e);
    int gap;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prime_p_i    <= p;
    prime_q_i    <= q;
    public_exp_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    expected_keys.push_back(derive_key(p, q, e));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result receiver: long holds, random stall bursts, or always ready.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    key_t k;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        k = expected_keys.pop_front();
        if (status_o !== k.status || exp_is_one_o !== k.flag || modulus_o !== k.n ||
            totient_o !== k.phi || private_exp_o !== k.d || private_exp_min_o !== k.dmin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: status %0d/%0d flag %0d/%0d n %0h/%0h", k.status, status_o,
                     k.flag, exp_is_one_o, k.n, modulus_o);
            $display("  phi %0h/%0h d %0h/%0h dmin %0h/%0h", k.phi, totient_o,
                     k.d, private_exp_o, k.dmin, private_exp_min_o);
          end
        end
      end
    end
  end

  // Field extremes and every error path.
  task automatic test_directed();
    send_request(0, 5, 3);
    send_request(7, 1, 5);
    send_request(1, 0, 1);
    send_request(2, 2, 0);
    send_request(2, 2, 1);
    send_request(2, 3, 1);
    send_request(3, 5, 0);
    send_request(5, 7, 1);
    send_request(5, 7, 6);
    send_request(9, 7, 5);
    send_request(4, 7, 5);
    send_request(7, 15, 5);
    send_request(7, 8, 5);
    send_request(11, 11, 3);
    send_request(61, 53, 17);
    send_request(61, 53, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd65537);
    send_request(32'hFFFF_FFFE, 32'hAAAA_5555, 64'd65537);
    send_request(13, 32'hFFFF_FFFF, 64'd65537);
    send_request(1048573, 1048571, 64'd65537);
    send_request(65521, 65519, 64'h8000_0000_0000_0001);
  endtask

  // Mostly valid key pairs with random exponents, plus broken requests.
  task automatic test_random(int count);
    logic [31:0] p, q;
    logic [63:0] e, phi;
    int tries;
    repeat (count) begin
      p = random_prime(($urandom_range(0, 4) == 0) ? 65535 : 4095);
      q = random_prime(($urandom_range(0, 4) == 0) ? 65535 : 4095);
      case ($urandom_range(0, 3))
        0: e = 64'd65537;
        1: e = $urandom_range(1, 1000);
        default: e = {$urandom(), $urandom()};
      endcase
      if ($urandom_range(0, 5) == 0) begin
        // Broken request: an even value or a multiple of three in place of one prime.
        if ($urandom_range(0, 1)) p = $urandom() & 32'hFFFF_FFFE;
        else q = 3 * $urandom_range(1, 32'h5555_5555);
      end else if ($urandom_range(0, 7) != 0) begin
        phi = (64'(p) - 1) * (64'(q) - 1);
        tries = 0;
        while (gcd64(e, phi) > 1 && tries < 64) begin
          e++;
          tries++;
        end
      end
      send_request(p, q, e);
    end
  endtask

  // Receiver holds off while the sender keeps offering requests.
  task automatic test_backpressure();
    hold_left = 400;
    repeat (4) send_request(random_prime(1023), random_prime(1023), 64'd65537);
  endtask

  // Sender pauses until every result is back, then resumes.
  task automatic test_drain_pause();
    wait_drain();
    repeat (3) send_request(random_prime(4095), random_prime(4095), 64'd3);
  endtask

  // Final stretch with both sides always active.
  task automatic test_steady();
    wait_drain();
    idle_en = 1'b0;
    test_random(15);
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(60);
    test_backpressure();
    test_drain_pause();
    test_steady();
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_keys.size() != 0 && wait_cycles < 5_000_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("** rsa_key_derivation: PASSED **");
    end else begin
      $display("** rsa_key_derivation: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200_000_000;
    $display("** rsa_key_derivation: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rsakd_pkg.sv
rtl/core/rsakd_divider.sv
rtl/core/rsakd_seq.sv
rtl/core/rsa_key_derivation.sv
rtl/core/rsakd_checker.sv
bench/tb_rsa_key_derivation.sv
